### rtl/rmpb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rmpb_pkg;

    localparam int CH_W   = 16;
    localparam int NUM_CH = 4;
    localparam int APB_DW = 64;
    localparam int APB_AW = 6;
    localparam int FAC_W  = 63;

    typedef enum logic [2:0] {
        MODE_CONST   = 3'd0,
        MODE_CHAN    = 3'd1,
        MODE_WEIGHT  = 3'd2,
        MODE_MERGE   = 3'd3,
        MODE_FILL    = 3'd4,
        MODE_REVFILL = 3'd5,
        MODE_CHDIFF  = 3'd6,
        MODE_TEXDIFF = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        REG_MODE    = 3'd0,
        REG_MASK    = 3'd1,
        REG_SELECT  = 3'd2,
        REG_FACTORS = 3'd3,
        REG_RED     = 3'd4,
        REG_GREEN   = 3'd5,
        REG_BLUE    = 3'd6,
        REG_ALPHA   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [CH_W-1:0] dest_red;
        logic [CH_W-1:0] dest_green;
        logic [CH_W-1:0] dest_blue;
        logic [CH_W-1:0] dest_alpha;
        logic [CH_W-1:0] src_red;
        logic [CH_W-1:0] src_green;
        logic [CH_W-1:0] src_blue;
        logic [CH_W-1:0] src_alpha;
        logic [CH_W-1:0] weight_value;
    } t_in;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
    } t_out;

    typedef struct packed {
        t_mode             mode;
        logic [NUM_CH-1:0] channel_mask;
        logic [1:0]        channel_select;
        logic [FAC_W-1:0]  channel_factors;
        logic [CH_W-1:0]   color_red;
        logic [CH_W-1:0]   color_green;
        logic [CH_W-1:0]   color_blue;
        logic [CH_W-1:0]   color_alpha;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic diff;
    } t_lane_ctl;

endpackage

`default_nettype wire

### rtl/rgba_masked_pixel_blend.sv
// Pipeline: lane multiply into the stage registers, then sum/merge into the output register.
// Throughput: one pixel per cycle unless output stalls; four lanes, one per channel.
// An output register and a pipeline register decouple the two sides under stall.
// Reset (synchronous, active low) empties the pipeline and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module rgba_masked_pixel_blend #(
    parameter int FRAC_BITS = 15
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rmpb_pkg::APB_AW-1:0] paddr,
    input  wire logic [rmpb_pkg::APB_DW-1:0] pwdata,
    output logic      [rmpb_pkg::APB_DW-1:0] prdata,
    output logic                             pready,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire rmpb_pkg::t_in               i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output rmpb_pkg::t_out                   o_out_data
);

    localparam int FW = FRAC_BITS + 1;
    localparam int SW = (FW > rmpb_pkg::CH_W) ? FW : rmpb_pkg::CH_W;
    localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;

    rmpb_pkg::t_cfg cfg;

    logic [rmpb_pkg::CH_W-1:0]   d   [rmpb_pkg::NUM_CH];
    logic [rmpb_pkg::CH_W-1:0]   s   [rmpb_pkg::NUM_CH];
    logic [rmpb_pkg::CH_W-1:0]   col [rmpb_pkg::NUM_CH];
    logic [rmpb_pkg::CH_W-1:0]   fac [rmpb_pkg::NUM_CH];
    logic [rmpb_pkg::CH_W-1:0]   x;
    logic [FW-1:0]               f0;
    logic [FW-1:0]               wx;
    logic [FW-1:0]               w;

    logic [rmpb_pkg::CH_W-1:0]   lane_a   [rmpb_pkg::NUM_CH];
    logic [rmpb_pkg::CH_W-1:0]   lane_b   [rmpb_pkg::NUM_CH];
    logic [FW-1:0]               lane_f   [rmpb_pkg::NUM_CH];
    logic                        lane_diff[rmpb_pkg::NUM_CH];
    logic [rmpb_pkg::CH_W-1:0]   lane_val [rmpb_pkg::NUM_CH];
    logic [rmpb_pkg::NUM_CH-1:0] n_wr;

    logic                        r_s1_valid;
    logic [rmpb_pkg::NUM_CH-1:0] r_s1_wr;
    logic [rmpb_pkg::CH_W-1:0]   r_s1_dest [rmpb_pkg::NUM_CH];
    logic                        r_out_valid;
    rmpb_pkg::t_out              r_out;
    logic [rmpb_pkg::CH_W-1:0]   res [rmpb_pkg::NUM_CH];

    logic s1_ld;
    logic out_ld;

    function automatic logic [FW-1:0] sat_f(input logic [rmpb_pkg::CH_W-1:0] f);
        logic [SW-1:0] fe;
        fe = SW'(f);
        if (fe > SW'(ONE)) begin
            return ONE;
        end
        return fe[FW-1:0];
    endfunction

    rmpb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // handshake
    assign out_ld      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || out_ld;
    assign s1_ld       = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ld) begin
                r_s1_valid <= 1'b1;
            end else if (out_ld) begin
                r_s1_valid <= 1'b0;
            end
            if (out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // operand selection
    always_comb begin
        d[0]   = i_in_data.dest_red;
        d[1]   = i_in_data.dest_green;
        d[2]   = i_in_data.dest_blue;
        d[3]   = i_in_data.dest_alpha;
        s[0]   = i_in_data.src_red;
        s[1]   = i_in_data.src_green;
        s[2]   = i_in_data.src_blue;
        s[3]   = i_in_data.src_alpha;
        col[0] = cfg.color_red;
        col[1] = cfg.color_green;
        col[2] = cfg.color_blue;
        col[3] = cfg.color_alpha;
        fac[0] = cfg.channel_factors[15:0];
        fac[1] = cfg.channel_factors[31:16];
        fac[2] = cfg.channel_factors[47:32];
        fac[3] = {1'b0, cfg.channel_factors[62:48]};
        x      = s[cfg.channel_select];
        f0     = sat_f(fac[0]);
        wx     = sat_f(x);
        w      = sat_f(i_in_data.weight_value);

        for (int c = 0; c < rmpb_pkg::NUM_CH; c++) begin
            n_wr[c]      = cfg.channel_mask[c];
            lane_a[c]    = d[c];
            lane_b[c]    = s[c];
            lane_f[c]    = f0;
            lane_diff[c] = 1'b0;
            case (cfg.mode)
                rmpb_pkg::MODE_CONST: begin
                    lane_b[c] = col[c];
                    lane_f[c] = sat_f(fac[c]);
                    n_wr[c]   = 1'b1;
                end
                rmpb_pkg::MODE_CHAN: begin
                    lane_b[c] = x;
                end
                rmpb_pkg::MODE_WEIGHT: begin
                    lane_f[c] = w;
                end
                rmpb_pkg::MODE_MERGE: begin
                    lane_f[c] = f0;
                end
                rmpb_pkg::MODE_FILL: begin
                    lane_a[c] = col[c];
                    lane_b[c] = d[c];
                    lane_f[c] = wx;
                end
                rmpb_pkg::MODE_REVFILL: begin
                    lane_b[c] = col[c];
                    lane_f[c] = wx;
                end
                rmpb_pkg::MODE_CHDIFF: begin
                    lane_a[c]    = d[cfg.channel_select];
                    lane_b[c]    = x;
                    lane_diff[c] = 1'b1;
                end
                rmpb_pkg::MODE_TEXDIFF: begin
                    lane_diff[c] = 1'b1;
                end
                default: begin
                    lane_diff[c] = 1'b1;
                end
            endcase
        end
    end

    for (genvar g = 0; g < rmpb_pkg::NUM_CH; g++) begin : g_lane
        rmpb_pkg::t_lane_ctl ctl;

        assign ctl.load = s1_ld;
        assign ctl.diff = lane_diff[g];

        rmpb_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_a     (lane_a[g]),
            .i_b     (lane_b[g]),
            .i_f     (lane_f[g]),
            .o_value (lane_val[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (s1_ld) begin
            r_s1_wr <= n_wr;
            for (int c = 0; c < rmpb_pkg::NUM_CH; c++) begin
                r_s1_dest[c] <= d[c];
            end
        end
    end

    // merge: write-enabled channels (masked, or all in const mode) take the lane result
    always_comb begin
        for (int c = 0; c < rmpb_pkg::NUM_CH; c++) begin
            res[c] = r_s1_wr[c] ? lane_val[c] : r_s1_dest[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ld) begin
            r_out.out_red   <= res[0];
            r_out.out_green <= res[1];
            r_out.out_blue  <= res[2];
            r_out.out_alpha <= res[3];
        end
    end

    a_s1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_ld |=> r_s1_valid)
        else $error("pipeline stage lost an accepted beat");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while pipeline full and stalled");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> o_in_ready)
        else $error("empty pipeline refuses input");

endmodule

`default_nettype wire

### rtl/rmpb_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module rmpb_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rmpb_pkg::APB_AW-1:0] paddr,
    input  wire logic [rmpb_pkg::APB_DW-1:0] pwdata,
    output logic      [rmpb_pkg::APB_DW-1:0] prdata,
    output logic                             pready,
    output rmpb_pkg::t_cfg                   o_cfg
);

    rmpb_pkg::t_cfg     r_cfg;
    rmpb_pkg::t_reg_idx idx;
    logic               wr_en;

    assign idx    = rmpb_pkg::t_reg_idx'(paddr[5:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode            <= rmpb_pkg::MODE_CONST;
            r_cfg.channel_mask    <= '1;
            r_cfg.channel_select  <= '0;
            r_cfg.channel_factors <= '0;
            r_cfg.color_red       <= '0;
            r_cfg.color_green     <= '0;
            r_cfg.color_blue      <= '0;
            r_cfg.color_alpha     <= '0;
        end else if (wr_en) begin
            unique case (idx)
                rmpb_pkg::REG_MODE:    r_cfg.mode <= rmpb_pkg::t_mode'(pwdata[2:0]);
                rmpb_pkg::REG_MASK:    r_cfg.channel_mask <= pwdata[3:0];
                rmpb_pkg::REG_SELECT:  r_cfg.channel_select <= pwdata[1:0];
                rmpb_pkg::REG_FACTORS: r_cfg.channel_factors <= pwdata[62:0];
                rmpb_pkg::REG_RED:     r_cfg.color_red <= pwdata[15:0];
                rmpb_pkg::REG_GREEN:   r_cfg.color_green <= pwdata[15:0];
                rmpb_pkg::REG_BLUE:    r_cfg.color_blue <= pwdata[15:0];
                rmpb_pkg::REG_ALPHA:   r_cfg.color_alpha <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            rmpb_pkg::REG_MODE:    prdata = {61'd0, r_cfg.mode};
            rmpb_pkg::REG_MASK:    prdata = {60'd0, r_cfg.channel_mask};
            rmpb_pkg::REG_SELECT:  prdata = {62'd0, r_cfg.channel_select};
            rmpb_pkg::REG_FACTORS: prdata = {1'b0, r_cfg.channel_factors};
            rmpb_pkg::REG_RED:     prdata = {48'd0, r_cfg.color_red};
            rmpb_pkg::REG_GREEN:   prdata = {48'd0, r_cfg.color_green};
            rmpb_pkg::REG_BLUE:    prdata = {48'd0, r_cfg.color_blue};
            rmpb_pkg::REG_ALPHA:   prdata = {48'd0, r_cfg.color_alpha};
            default:               prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/rmpb_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module rmpb_lane #(
    parameter int FRAC_BITS = 15
) (
    input  wire logic                          i_clk,
    input  wire rmpb_pkg::t_lane_ctl           i_ctl,
    input  wire logic [rmpb_pkg::CH_W-1:0]     i_a,
    input  wire logic [rmpb_pkg::CH_W-1:0]     i_b,
    input  wire logic [FRAC_BITS:0]            i_f,
    output logic      [rmpb_pkg::CH_W-1:0]     o_value
);

    localparam int FW = FRAC_BITS + 1;
    localparam int PW = rmpb_pkg::CH_W + FW;
    localparam logic [FW-1:0] ONE  = FW'(1) << FRAC_BITS;
    localparam logic [PW:0]   HALF = (PW+1)'(1) << (FRAC_BITS - 1);

    logic [FW-1:0]             one_minus;
    logic [PW-1:0]             n_pa;
    logic [PW-1:0]             n_pb;
    logic [rmpb_pkg::CH_W-1:0] n_diff;
    logic [PW-1:0]             r_pa;
    logic [PW-1:0]             r_pb;
    logic [rmpb_pkg::CH_W-1:0] r_diff;
    logic                      r_is_diff;
    logic [PW:0]               sum;

    assign one_minus = ONE - i_f;
    assign n_pa      = PW'(i_a) * PW'(one_minus);
    assign n_pb      = PW'(i_b) * PW'(i_f);
    assign n_diff    = (i_a > i_b) ? (i_a - i_b) : (i_b - i_a);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_pa      <= n_pa;
            r_pb      <= n_pb;
            r_diff    <= n_diff;
            r_is_diff <= i_ctl.diff;
        end
    end

    // round half up, then drop the fraction
    assign sum     = (PW+1)'(r_pa) + (PW+1)'(r_pb) + HALF;
    assign o_value = r_is_diff ? r_diff : sum[FRAC_BITS +: rmpb_pkg::CH_W];

endmodule

`default_nettype wire

### verif/rgba_blend_checker.sv
`timescale 1ns / 1ps

module rgba_blend_checker #(
    parameter int FRAC_BITS = 15
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic                        pready,
    input  wire logic [rmpb_pkg::APB_AW-1:0] paddr,
    input  wire logic [rmpb_pkg::APB_DW-1:0] pwdata,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_ready,
    input  wire rmpb_pkg::t_in               i_in_data,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_ready,
    input  wire rmpb_pkg::t_out              i_out_data,
    output int                               o_mismatches,
    output int                               o_pending
);

    localparam int          CH_W       = rmpb_pkg::CH_W;
    localparam int          NUM_CH     = rmpb_pkg::NUM_CH;
    localparam int          FAC_W      = rmpb_pkg::FAC_W;
    localparam int          APB_AW     = rmpb_pkg::APB_AW;
    localparam logic [31:0] ONE_Q      = 32'd1 << FRAC_BITS;
    localparam int          MAX_PRINTS = 40;

    rmpb_pkg::t_out expected_pixels[$];
    rmpb_pkg::t_cfg blend_cfg;
    int             mismatch_count = 0;

    // weights and factors above one saturate
    function automatic logic [31:0] clamp_factor(input logic [CH_W-1:0] f);
        return ({16'd0, f} > ONE_Q) ? ONE_Q : {16'd0, f};
    endfunction

    // a*(1-f) + b*f, rounded half up
    function automatic logic [CH_W-1:0] mix(input logic [CH_W-1:0] a,
                                            input logic [CH_W-1:0] b,
                                            input logic [31:0]     f);
        logic [63:0] acc;
        acc = 64'(a) * 64'(ONE_Q - f) + 64'(b) * 64'(f) + 64'(ONE_Q >> 1);
        return acc[FRAC_BITS +: CH_W];
    endfunction

    function automatic logic [CH_W-1:0] absdiff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic rmpb_pkg::t_out blend_pixel(input rmpb_pkg::t_in px,
                                                   input rmpb_pkg::t_cfg cfg);
        logic [NUM_CH-1:0][CH_W-1:0] d;
        logic [NUM_CH-1:0][CH_W-1:0] s;
        logic [NUM_CH-1:0][CH_W-1:0] col;
        logic [NUM_CH-1:0][CH_W-1:0] res;
        logic [63:0]                 lanes;
        logic [CH_W-1:0]             x;
        logic [CH_W-1:0]             v;
        logic [31:0]                 f0;
        logic [31:0]                 wx;
        logic [31:0]                 w;
        logic                        wr;
        int                          c;
        d     = {px.dest_alpha, px.dest_blue, px.dest_green, px.dest_red};
        s     = {px.src_alpha, px.src_blue, px.src_green, px.src_red};
        col   = {cfg.color_alpha, cfg.color_blue, cfg.color_green, cfg.color_red};
        lanes = {1'b0, cfg.channel_factors};
        x     = s[cfg.channel_select];
        f0    = clamp_factor(lanes[CH_W-1:0]);
        wx    = clamp_factor(x);
        w     = clamp_factor(px.weight_value);
        for (c = 0; c < NUM_CH; c++) begin
            wr = cfg.channel_mask[c];
            case (cfg.mode)
                rmpb_pkg::MODE_CONST: begin
                    v  = mix(d[c], col[c], clamp_factor(lanes[CH_W*c +: CH_W]));
                    wr = 1'b1;
                end
                rmpb_pkg::MODE_CHAN:    v = mix(d[c], x, f0);
                rmpb_pkg::MODE_WEIGHT:  v = mix(d[c], s[c], w);
                rmpb_pkg::MODE_MERGE:   v = mix(d[c], s[c], f0);
                rmpb_pkg::MODE_FILL:    v = mix(col[c], d[c], wx);
                rmpb_pkg::MODE_REVFILL: v = mix(d[c], col[c], wx);
                rmpb_pkg::MODE_CHDIFF:  v = absdiff(d[cfg.channel_select], x);
                default:                v = absdiff(d[c], s[c]);
            endcase
            res[c] = wr ? v : d[c];
        end
        return '{out_red: res[0], out_green: res[1], out_blue: res[2], out_alpha: res[3]};
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t: pixel mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        rmpb_pkg::t_out want;
        if (!i_rst_n) begin
            blend_cfg = '{mode: rmpb_pkg::MODE_CONST, channel_mask: 4'hF,
                          channel_select: 2'd0, channel_factors: '0,
                          color_red: '0, color_green: '0,
                          color_blue: '0, color_alpha: '0};
            expected_pixels.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("beat %h with nothing expected", i_out_data));
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_out_data.out_red !== want.out_red)
                        report_mismatch($sformatf("red got %h want %h",
                                                  i_out_data.out_red, want.out_red));
                    if (i_out_data.out_green !== want.out_green)
                        report_mismatch($sformatf("green got %h want %h",
                                                  i_out_data.out_green, want.out_green));
                    if (i_out_data.out_blue !== want.out_blue)
                        report_mismatch($sformatf("blue got %h want %h",
                                                  i_out_data.out_blue, want.out_blue));
                    if (i_out_data.out_alpha !== want.out_alpha)
                        report_mismatch($sformatf("alpha got %h want %h",
                                                  i_out_data.out_alpha, want.out_alpha));
                end
            end
            if (i_in_valid && i_in_ready)
                expected_pixels.push_back(blend_pixel(i_in_data, blend_cfg));
            if (psel && penable && pwrite && pready) begin
                case (rmpb_pkg::t_reg_idx'(paddr[APB_AW-1:3]))
                    rmpb_pkg::REG_MODE:
                        blend_cfg.mode = rmpb_pkg::t_mode'(pwdata[2:0]);
                    rmpb_pkg::REG_MASK:
                        blend_cfg.channel_mask = pwdata[NUM_CH-1:0];
                    rmpb_pkg::REG_SELECT:
                        blend_cfg.channel_select = pwdata[1:0];
                    rmpb_pkg::REG_FACTORS:
                        blend_cfg.channel_factors = pwdata[FAC_W-1:0];
                    rmpb_pkg::REG_RED:
                        blend_cfg.color_red = pwdata[CH_W-1:0];
                    rmpb_pkg::REG_GREEN:
                        blend_cfg.color_green = pwdata[CH_W-1:0];
                    rmpb_pkg::REG_BLUE:
                        blend_cfg.color_blue = pwdata[CH_W-1:0];
                    default:
                        blend_cfg.color_alpha = pwdata[CH_W-1:0];
                endcase
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_pixels.size();
    end

endmodule

### verif/tb_rgba_masked_pixel_blend.sv
`timescale 1ns / 1ps

module tb_rgba_masked_pixel_blend;

    localparam int              CH_W          = rmpb_pkg::CH_W;
    localparam int              APB_AW        = rmpb_pkg::APB_AW;
    localparam int              APB_DW        = rmpb_pkg::APB_DW;
    localparam int              RANDOM_PHASES = 16;
    localparam int              PHASE_PIXELS  = 120;
    localparam int              STALL_LIMIT   = 2000;
    localparam logic [CH_W-1:0] ONE_Q         = 16'h8000;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    rmpb_pkg::t_in     in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    rmpb_pkg::t_out    out_data;
    int                mismatches;
    int                pending;
    int                src_idle_pct   = 0;
    int                sink_stall_pct = 0;
    int                quiet_cycles   = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    rgba_masked_pixel_blend dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    rgba_blend_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // mostly in range, with zero, one, all ones and above-one values mixed in
    function automatic logic [CH_W-1:0] rand_level();
        case ($urandom_range(11))
            0:       return '0;
            1:       return ONE_Q;
            2:       return '1;
            3, 4:    return CH_W'($urandom_range(16'hFFFF));
            default: return CH_W'($urandom_range(32768));
        endcase
    endfunction

    function automatic rmpb_pkg::t_in rand_pixel();
        return '{dest_red: rand_level(), dest_green: rand_level(),
                 dest_blue: rand_level(), dest_alpha: rand_level(),
                 src_red: rand_level(), src_green: rand_level(),
                 src_blue: rand_level(), src_alpha: rand_level(),
                 weight_value: rand_level()};
    endfunction

    function automatic rmpb_pkg::t_cfg rand_setting(input rmpb_pkg::t_mode m);
        return '{mode: m, channel_mask: 4'($urandom_range(15)),
                 channel_select: 2'($urandom_range(3)),
                 channel_factors: {15'($urandom_range(16'h7FFF)), rand_level(),
                                   rand_level(), rand_level()},
                 color_red: rand_level(), color_green: rand_level(),
                 color_blue: rand_level(), color_alpha: rand_level()};
    endfunction

    task automatic set_idling(input int kind);
        case (kind)
            0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1:       begin src_idle_pct = 46; sink_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  sink_stall_pct = 46; end
            default: begin src_idle_pct = 28; sink_stall_pct = 28; end
        endcase
    endtask

    task automatic write_reg(input rmpb_pkg::t_reg_idx idx,
                             input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 3'b000});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_blend(input rmpb_pkg::t_cfg cfg);
        write_reg(rmpb_pkg::REG_MODE,    APB_DW'(cfg.mode));
        write_reg(rmpb_pkg::REG_MASK,    APB_DW'(cfg.channel_mask));
        write_reg(rmpb_pkg::REG_SELECT,  APB_DW'(cfg.channel_select));
        write_reg(rmpb_pkg::REG_FACTORS, APB_DW'(cfg.channel_factors));
        write_reg(rmpb_pkg::REG_RED,     APB_DW'(cfg.color_red));
        write_reg(rmpb_pkg::REG_GREEN,   APB_DW'(cfg.color_green));
        write_reg(rmpb_pkg::REG_BLUE,    APB_DW'(cfg.color_blue));
        write_reg(rmpb_pkg::REG_ALPHA,   APB_DW'(cfg.color_alpha));
    endtask

    task automatic send_pixel(input rmpb_pkg::t_in px);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        @(posedge i_clk);
        while (!in_ready)
            @(posedge i_clk);
    endtask

    // wait until the checker expects no more beats, then idle before the next phase
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        rmpb_pkg::t_cfg  cfg;
        logic [CH_W-1:0] lane0;
        int              m;
        int              p;
        int              n;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: each mode with zero, all-ones and mid-range pixels;
        // zero and saturating factor lanes, mask 0 in const mode
        for (m = 0; m < 8; m++) begin
            lane0 = (m == 0) ? 16'h0000 : (m[0] ? 16'hFFFF : 16'h2000);
            cfg = '{mode: rmpb_pkg::t_mode'(m), channel_mask: 4'(m * 7),
                    channel_select: 2'(m),
                    channel_factors: {15'h4000, 16'hFFFF, ONE_Q, lane0},
                    color_red: 16'hFFFF, color_green: ONE_Q, color_blue: 16'h0000,
                    color_alpha: 16'h3C00};
            program_blend(cfg);
            send_pixel('0);
            send_pixel('1);
            send_pixel('{dest_red: ONE_Q, dest_green: ONE_Q, dest_blue: ONE_Q,
                         dest_alpha: ONE_Q, src_red: 16'h0001, src_green: 16'h7FFF,
                         src_blue: ONE_Q, src_alpha: 16'hC000, weight_value: 16'h4000});
            in_valid <= 1'b0;
            wait_drained();
        end

        for (p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0)
                cfg = '{mode: rmpb_pkg::MODE_TEXDIFF, channel_mask: '1,
                        channel_select: 2'd3, channel_factors: '1,
                        color_red: '1, color_green: '1,
                        color_blue: '1, color_alpha: '1};
            else if (p == 1)
                cfg = '{mode: rmpb_pkg::MODE_CONST, channel_mask: '0,
                        channel_select: 2'd0, channel_factors: '0,
                        color_red: '0, color_green: '0,
                        color_blue: '0, color_alpha: '0};
            else
                cfg = rand_setting(rmpb_pkg::t_mode'(p % 8));
            program_blend(cfg);
            set_idling(p % 4);
            for (n = 0; n < PHASE_PIXELS; n++)
                send_pixel(rand_pixel());
            in_valid <= 1'b0;
            wait_drained();
        end

        if (mismatches == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
